// File: sv/swa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and codes of the split-word read-modify-write ALU.
// ----------------------------------------------------------------------------
package swa_pkg;

  // Request codes; codes above REQ_SHR do nothing
  typedef enum logic [3:0] {
    REQ_WRITE = 4'd0,
    REQ_READ  = 4'd1,
    REQ_ADD   = 4'd2,
    REQ_SUB   = 4'd3,
    REQ_MUL   = 4'd4,
    REQ_DIV   = 4'd5,
    REQ_MOD   = 4'd6,
    REQ_SHL   = 4'd7,
    REQ_SHR   = 4'd8
  } req_e;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_EXEC,
    ST_DIV,
    ST_WB_LO,
    ST_WB_HI,
    ST_DONE
  } state_e;

  // Command into the divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_cmd_t;

  // Answer from the divider
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/swa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swa_req_if / swa_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface swa_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [15:0] addr_low;
  logic [15:0] addr_high;
  logic [31:0] operand;
  logic [15:0] write_data;

  modport source (
    output valid, req_type, addr_low, addr_high, operand, write_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, addr_low, addr_high, operand, write_data,
    output ready
  );
endinterface

interface swa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        div_by_zero;

  modport source (
    output valid, result_value, div_by_zero,
    input  ready
  );
  modport sink (
    input  valid, result_value, div_by_zero,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/swa_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swa_mem
// Word memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swa_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned Aw    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/swa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swa_div
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swa_div
  import swa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = cmd_i.dividend;
      dvs_d  = cmd_i.divisor;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
      end
      quo_d = {quo_q[30:0], ~trial[32]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// File: sv/split_word_alu_rmw_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// split_word_alu_rmw_top
// Memory of 16-bit words with a 32-bit ALU working on split low/high words.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req_i    in   req_type, addr_low, addr_high, operand, write_data
//  rsp_o    out  result_value, div_by_zero
//
//  A divide or modulo waits on the 32-step divider, a zero divisor skips
//  it and the writeback; the memory's single read and single write port
//  serialize the low and high accesses.
//  One item is in work at a time; the next is taken once the current result
//  sits in the output register, which holds it under a stalled sink.
//  Reset clears control only; the memory holds no value until written.
// ----------------------------------------------------------------------------
module split_word_alu_rmw_top
  import swa_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swa_req_if.sink   req_i,
  swa_rsp_if.source rsp_o
);

  localparam int unsigned Aw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  // ceil(2^32 / MEM_WORDS): exact quotient for any 16-bit address
  localparam longint unsigned RecipL = (64'h1_0000_0000 + MEM_WORDS - 1) / MEM_WORDS;
  localparam logic [32:0] Recip = RecipL[32:0];
  localparam logic [31:0] Words = 32'(MEM_WORDS);

  state_e      state_q, state_d;
  logic [3:0]  req_q;
  logic [15:0] alo_raw_q, ahi_raw_q;
  logic [15:0] qlo_q, qhi_q;
  logic [31:0] opd_q;
  logic [15:0] wdata_q;
  logic [15:0] lo_q, lo_d;
  logic [31:0] res_q, res_d;
  logic        dz_q, dz_d;
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic        out_dz_q;

  logic [48:0] prod_lo, prod_hi;
  logic [31:0] alo_w, ahi_w;
  logic [Aw-1:0] alo, ahi;
  logic [31:0] cur;
  logic [63:0] mul_full;

  logic          mem_we;
  logic [Aw-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;
  div_cmd_t      div_cmd;
  div_rsp_t      div_rsp;

  logic accept, out_load;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // address wrap: quotient by reciprocal at accept, remainder next cycle
  assign prod_lo = 49'(req_i.addr_low) * 49'(Recip);
  assign prod_hi = 49'(req_i.addr_high) * 49'(Recip);
  assign alo_w   = {16'd0, alo_raw_q} - 32'(qlo_q) * Words;
  assign ahi_w   = {16'd0, ahi_raw_q} - 32'(qhi_q) * Words;
  assign alo     = alo_w[Aw-1:0];
  assign ahi     = ahi_w[Aw-1:0];

  // current 32-bit value, high word straight from the read port
  assign cur      = {mem_rdata, lo_q};
  assign mul_full = 64'(cur) * 64'(opd_q);

  // sequencer: ops read low, read high, compute, write low, write high
  always_comb begin
    state_d          = state_q;
    lo_d             = lo_q;
    res_d            = res_q;
    dz_d             = dz_q;
    mem_we           = 1'b0;
    mem_waddr        = alo;
    mem_wdata        = res_q[15:0];
    mem_raddr        = alo;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = cur;
    div_cmd.divisor  = opd_q;
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        dz_d = 1'b0;
        unique case (req_q) inside
          REQ_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = wdata_q;
            res_d     = {16'd0, wdata_q};
            state_d   = ST_DONE;
          end
          REQ_READ, REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_MOD, REQ_SHL, REQ_SHR: begin
            state_d = ST_RD_HI;
          end
          default: begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RD_HI: begin
        mem_raddr = ahi;
        lo_d      = mem_rdata;
        if (req_q == REQ_READ) begin
          res_d   = {16'd0, mem_rdata};
          state_d = ST_DONE;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_WB_LO;
        unique case (req_q) inside
          REQ_ADD: res_d = cur + opd_q;
          REQ_SUB: res_d = cur - opd_q;
          REQ_MUL: res_d = mul_full[31:0];
          REQ_SHL: res_d = cur << opd_q[4:0];
          REQ_SHR: res_d = cur >> opd_q[4:0];
          REQ_DIV, REQ_MOD: begin
            if (opd_q == '0) begin
              dz_d    = 1'b1;
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              div_cmd.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          default: res_d = res_q;
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_d   = (req_q == REQ_MOD) ? div_rsp.remainder : div_rsp.quotient;
          state_d = ST_WB_LO;
        end
      end
      ST_WB_LO: begin
        mem_we  = 1'b1;
        state_d = ST_WB_HI;
      end
      ST_WB_HI: begin
        // high word last: it wins when both addresses match
        mem_we    = 1'b1;
        mem_waddr = ahi;
        mem_wdata = res_q[31:16];
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i.req_type;
      alo_raw_q <= req_i.addr_low;
      ahi_raw_q <= req_i.addr_high;
      qlo_q     <= prod_lo[47:32];
      qhi_q     <= prod_hi[47:32];
      opd_q     <= req_i.operand;
      wdata_q   <= req_i.write_data;
    end
    lo_q  <= lo_d;
    res_q <= res_d;
    dz_q  <= dz_d;
    if (out_load) begin
      out_value_q <= res_q;
      out_dz_q    <= dz_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.div_by_zero  = out_dz_q;

  swa_mem #(
    .Depth (MEM_WORDS),
    .Aw    (Aw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  swa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the split-word read-modify-write ALU. A queue of
// request items feeds a valid/ready driver; a shadow copy of the word memory
// predicts every result, which is checked against the result channel in
// order. Idle and stall rates change over several phases, including one long
// sink hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb;
  import swa_pkg::*;

  localparam int unsigned CLK_HALF    = 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 85;

  // Request codes with no operation behind them
  localparam logic [3:0] REQ_UNUSED_LO = 4'd9;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

  typedef struct {
    logic [3:0]  req_type;
    logic [15:0] addr_low;
    logic [15:0] addr_high;
    logic [31:0] operand;
    logic [15:0] write_data;
  } alu_req_t;

  typedef struct {
    logic [31:0] result_value;
    logic        div_by_zero;
  } alu_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  swa_req_if req_if ();
  swa_rsp_if rsp_if ();

  split_word_alu_rmw_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Stimulus and prediction state
  alu_req_t    pending_reqs[$];
  alu_rsp_t    expected_rsps[$];
  logic [15:0] shadow_mem [0:65535];
  bit          written_map [0:65535];
  logic [15:0] live_addrs[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  logic        req_taken = 1'b0;
  bit          hold_trig = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // Addresses that see a large share of the traffic, so that items collide often
  function automatic logic [15:0] hot_addr(int unsigned idx);
    case (idx)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      4: return 16'h5555;
      5: return 16'hAAAA;
      6: return 16'h7FFF;
      default: return 16'h1234;
    endcase
  endfunction

  function automatic void mark_written(logic [15:0] a);
    if (!written_map[a]) begin
      written_map[a] = 1'b1;
      live_addrs.push_back(a);
    end
  endfunction

  // Only words already written may be read back
  function automatic logic [15:0] pick_live();
    logic [15:0] a;
    a = hot_addr($urandom_range(7));
    if ($urandom_range(1) == 0 || !written_map[a])
      a = live_addrs[$urandom_range(live_addrs.size() - 1)];
    return a;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4, 5: return 32'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_req_t gen_request();
    alu_req_t    it;
    int unsigned r;
    r = $urandom_range(99);
    it.operand    = $urandom;
    it.write_data = 16'($urandom);
    it.addr_high  = 16'($urandom);
    if (r < 20) begin
      it.req_type = REQ_WRITE;
      it.addr_low = ($urandom_range(1) == 0) ? hot_addr($urandom_range(7)) : 16'($urandom);
      case ($urandom_range(4))
        0: it.write_data = 16'h0000;
        1: it.write_data = 16'hFFFF;
        default: ;
      endcase
      mark_written(it.addr_low);
    end else if (r < 34) begin
      it.req_type = REQ_READ;
      it.addr_low = pick_live();
    end else if (r < 37) begin
      it.req_type = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      it.addr_low = 16'($urandom);
    end else begin
      it.req_type  = 4'($urandom_range(REQ_ADD, REQ_SHR));
      it.addr_low  = pick_live();
      it.addr_high = ($urandom_range(99) < 15) ? it.addr_low : pick_live();
      it.operand   = pick_operand();
    end
    return it;
  endfunction

  task automatic push_req(logic [3:0] kind, logic [15:0] lo, logic [15:0] hi,
                          logic [31:0] opnd, logic [15:0] wd);
    alu_req_t it;
    it.req_type   = kind;
    it.addr_low   = lo;
    it.addr_high  = hi;
    it.operand    = opnd;
    it.write_data = wd;
    if (kind == REQ_WRITE)
      mark_written(lo);
    pending_reqs.push_back(it);
  endtask

  // Read-modify-write on the shadow memory; low word first, high word wins
  function automatic alu_rsp_t alu_rmw_predict(alu_req_t it);
    alu_rsp_t    e;
    logic [31:0] cur;
    logic        wb;
    e.result_value = 32'h0;
    e.div_by_zero  = 1'b0;
    wb  = 1'b0;
    cur = {shadow_mem[it.addr_high], shadow_mem[it.addr_low]};
    case (it.req_type)
      REQ_WRITE: begin
        shadow_mem[it.addr_low] = it.write_data;
        e.result_value = {16'h0000, it.write_data};
      end
      REQ_READ: e.result_value = {16'h0000, shadow_mem[it.addr_low]};
      REQ_ADD: begin
        e.result_value = cur + it.operand;
        wb = 1'b1;
      end
      REQ_SUB: begin
        e.result_value = cur - it.operand;
        wb = 1'b1;
      end
      REQ_MUL: begin
        e.result_value = cur * it.operand;
        wb = 1'b1;
      end
      REQ_DIV, REQ_MOD: begin
        if (it.operand == 32'h0) begin
          e.div_by_zero = 1'b1;
        end else begin
          e.result_value = (it.req_type == REQ_DIV) ? cur / it.operand : cur % it.operand;
          wb = 1'b1;
        end
      end
      REQ_SHL: begin
        e.result_value = cur << it.operand[4:0];
        wb = 1'b1;
      end
      REQ_SHR: begin
        e.result_value = cur >> it.operand[4:0];
        wb = 1'b1;
      end
      default: ;
    endcase
    if (wb) begin
      shadow_mem[it.addr_low]  = e.result_value[15:0];
      shadow_mem[it.addr_high] = e.result_value[31:16];
    end
    return e;
  endfunction

  // Request driver: next item at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    alu_req_t nxt;
    logic     drive_valid;
    drive_valid = req_if.valid;
    if (rst_ni && (!req_if.valid || req_taken)) begin
      drive_valid = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        drive_valid          = 1'b1;
        req_if.req_type     <= nxt.req_type;
        req_if.addr_low     <= nxt.addr_low;
        req_if.addr_high    <= nxt.addr_high;
        req_if.operand      <= nxt.operand;
        req_if.write_data   <= nxt.write_data;
      end
    end
    req_if.valid <= drive_valid;
  end

  // Result sink: random stalls, plus the long hold-off when one is running
  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold-off counter, started by a toggle of hold_trig
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: predict accepted requests, check accepted results
  always @(posedge clk_i) begin
    alu_req_t it;
    alu_rsp_t e;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        it.req_type   = req_if.req_type;
        it.addr_low   = req_if.addr_low;
        it.addr_high  = req_if.addr_high;
        it.operand    = req_if.operand;
        it.write_data = req_if.write_data;
        expected_rsps.push_back(alu_rmw_predict(it));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual value %h flag %b",
                   $time, rsp_if.result_value, rsp_if.div_by_zero);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp_if.result_value !== e.result_value) begin
            mismatch_count++;
            $display("%0t: result_value mismatch: expected %h actual %h", $time,
                     e.result_value, rsp_if.result_value);
          end
          if (rsp_if.div_by_zero !== e.div_by_zero) begin
            mismatch_count++;
            $display("%0t: div_by_zero mismatch: expected %b actual %b", $time,
                     e.div_by_zero, rsp_if.div_by_zero);
          end
        end
      end
    end
  end

  // Wait until every queued item is taken and every result has come back
  task automatic drain_all();
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  // Sequence of phases
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = 4'h0;
    req_if.addr_low   = 16'h0;
    req_if.addr_high  = 16'h0;
    req_if.operand    = 32'h0;
    req_if.write_data = 16'h0;
    rsp_if.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: wrap on add/sub, full-width mul, zero divisors, shift amounts
    // beyond 31, equal addresses, unused codes, top of the address range
    push_req(REQ_WRITE, 16'h0000, 16'h1111, 32'h0, 16'hFFFF);
    push_req(REQ_WRITE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(REQ_ADD,   16'h0000, 16'hFFFF, 32'h0000_0001, 16'h0);
    push_req(REQ_SUB,   16'h0000, 16'hFFFF, 32'h0000_0001, 16'h0);
    push_req(REQ_READ,  16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(REQ_WRITE, 16'h8000, 16'h0000, 32'h0, 16'h0000);
    push_req(REQ_WRITE, 16'h0001, 16'h0000, 32'h0, 16'h8000);
    push_req(REQ_MUL,   16'h8000, 16'h0001, 32'hFFFF_FFFF, 16'h0);
    push_req(REQ_DIV,   16'h0000, 16'hFFFF, 32'h0000_0007, 16'h0);
    push_req(REQ_MOD,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    push_req(REQ_DIV,   16'h0000, 16'hFFFF, 32'h0000_0000, 16'h0);
    push_req(REQ_MOD,   16'h8000, 16'h0001, 32'h0000_0000, 16'h0);
    push_req(REQ_SHL,   16'h8000, 16'h0001, 32'h0000_0021, 16'h0);
    push_req(REQ_SHR,   16'h8000, 16'h0001, 32'h0000_001F, 16'h0);
    push_req(REQ_SHL,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    push_req(REQ_WRITE, 16'h5555, 16'hAAAA, 32'h0, 16'h1234);
    push_req(REQ_ADD,   16'h5555, 16'h5555, 32'h0001_0000, 16'h0);
    push_req(REQ_READ,  16'h5555, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_UNUSED_LO, 16'hAAAA, 16'h7FFF, 32'h1234_5678, 16'hFFFF);
    push_req(REQ_UNUSED_HI, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0);
    push_req(REQ_WRITE, 16'hAAAA, 16'h0000, 32'h0, 16'hFFFF);
    push_req(REQ_WRITE, 16'h7FFF, 16'h0000, 32'h0, 16'h0001);
    push_req(REQ_WRITE, 16'h1234, 16'h0000, 32'h0, 16'h00FF);
    push_req(REQ_SHR,   16'hAAAA, 16'h7FFF, 32'h0000_0000, 16'h0);
    push_req(REQ_READ,  16'hFFFF, 16'hFFFF, 32'h0, 16'h0);
    drain_all();

    // Random phases: none, sender idle, sink stall, both lightly
    for (int rnd = 0; rnd < 2; rnd++) begin
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
          default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
        repeat (PHASE_ITEMS) pending_reqs.push_back(gen_request());
        drain_all();
      end
    end

    // Long sink hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_trig = ~hold_trig;
    @(posedge clk_i);
    repeat (60) pending_reqs.push_back(gen_request());
    drain_all();

    repeat (60) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never came", $time, expected_rsps.size());
    end
    if (mismatch_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
sv/swa_pkg.sv
sv/swa_if.sv
sv/swa_mem.sv
sv/swa_div.sv
sv/split_word_alu_rmw_top.sv
tb/tb.sv
